### rtl/mwe_pkg.sv
// Shared types, constants and helper functions for the warp escape-time engine.
// No dependencies; the front end, back end, top level and bench refer to it by scoped names.
`timescale 1ns / 1ps
package mwe_pkg;

   localparam int WarpWidthDefault  = 32;
   localparam int CoordWidthDefault = 32;
   localparam int FracBits          = 28;
   localparam int ResultCap         = 32;
   localparam int QueueDepth        = 2;

   localparam int SizeWidth  = 13;
   localparam int IterWidth  = 16;
   localparam int PixWidth   = 12;
   localparam int LaneWidth  = 5;
   localparam int DivWidth   = 17;
   localparam int SlotWidth  = 21;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 48;

   localparam logic [SizeWidth-1:0] SizeMin = 13'd2;
   localparam logic [SizeWidth-1:0] SizeMax = 13'd4096;
   localparam logic [IterWidth-1:0] LimitDefault = 16'd128;

   // register indexes
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_IMAGE_WIDTH     = 3'd0,
      CSR_IMAGE_HEIGHT    = 3'd1,
      CSR_ITERATION_LIMIT = 3'd2,
      CSR_REAL_MIN        = 3'd3,
      CSR_REAL_MAX        = 3'd4,
      CSR_IMAG_MIN        = 3'd5,
      CSR_IMAG_MAX        = 3'd6,
      CSR_UNUSED          = 3'd7
   } csr_idx_type;

   // front end states
   typedef enum logic [2:0] {
      FE_IDLE,
      FE_ROW_MUL,
      FE_ROW_DIV,
      FE_COL_MUL,
      FE_COL_DIV,
      FE_PUSH
   } fe_state_type;

   // back end states
   typedef enum logic [1:0] {
      BE_IDLE,
      BE_RUN,
      BE_EMIT
   } be_state_type;

   // clamp a size register into the legal image range
   function automatic logic [SizeWidth-1:0] clamp_size(input logic [SizeWidth-1:0] s);
      logic [SizeWidth-1:0] r;
      r = s;
      if (s < SizeMin) r = SizeMin;
      if (s > SizeMax) r = SizeMax;
      return r;
   endfunction

endpackage

### rtl/mwe_divider.sv
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on mwe_pkg only through the caller's widths.
`timescale 1ns / 1ps
module mwe_divider #(
   parameter int NumWidth = 46,
   parameter int DenWidth = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [NumWidth-1:0] numer,
   input  logic [DenWidth-1:0]        denom,
   output logic                       done,
   output logic signed [NumWidth-1:0] quot
);
   localparam int CntWidth = $clog2(NumWidth + 1);

   logic [NumWidth-1:0] mag_ff, mag_in;
   logic [DenWidth:0]   rem_ff, rem_in;
   logic [DenWidth-1:0] den_ff, den_in;
   logic                neg_ff, neg_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DenWidth:0]   trial;

   // shift one numerator bit into the partial remainder per cycle
   always_comb begin
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DenWidth-1:0], mag_ff[NumWidth-1]};
      if (start) begin
         neg_in  = numer[NumWidth-1];
         mag_in  = numer[NumWidth-1] ? (~numer + 1'b1) : numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CntWidth'(NumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            mag_in = {mag_ff[NumWidth-2:0], 1'b1};
         end else begin
            rem_in = trial;
            mag_in = {mag_ff[NumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? $signed(~mag_ff + 1'b1) : $signed(mag_ff);
endmodule

### rtl/mwe_front.sv
// Front end: clamps the warp coordinates and maps each lane pixel to c.
// Depends on mwe_pkg and mwe_divider; pushes one lane record per lane.
`timescale 1ns / 1ps
module mwe_front #(
   parameter int Lanes      = 32,
   parameter int CoordWidth = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mwe_pkg::PixWidth-1:0]  req_first_column,
   input  logic [mwe_pkg::PixWidth-1:0]  req_row,
   input  logic [mwe_pkg::SizeWidth-1:0] width_cfg,
   input  logic [mwe_pkg::SizeWidth-1:0] height_cfg,
   input  logic signed [CoordWidth-1:0]  real_min,
   input  logic signed [CoordWidth-1:0]  real_max,
   input  logic signed [CoordWidth-1:0]  imag_min,
   input  logic signed [CoordWidth-1:0]  imag_max,
   output logic                          push,
   input  logic                          push_ready,
   output logic [mwe_pkg::LaneWidth-1:0] push_lane,
   output logic [mwe_pkg::PixWidth-1:0]  push_col,
   output logic signed [CoordWidth+3:0]  push_cr,
   output logic signed [CoordWidth+3:0]  push_ci
);
   localparam int LaneW  = mwe_pkg::LaneWidth;
   localparam int PixW   = mwe_pkg::PixWidth;
   localparam int VW     = CoordWidth + 4;
   localparam int SpanW  = CoordWidth + 1;
   localparam int ProdW  = SpanW + PixW + 1;

   mwe_pkg::fe_state_type state_ff, state_in;
   logic [PixW-1:0]  first_ff, first_in;
   logic [PixW-1:0]  row_ff, row_in;
   logic [LaneW-1:0] lane_ff, lane_in;
   logic [PixW-1:0]  col_ff, col_in;
   logic signed [VW-1:0] ci_ff, ci_in;
   logic signed [ProdW-1:0] prod_ff, prod_in;
   logic [PixW-1:0]  wm1, hm1;
   logic [mwe_pkg::SizeWidth-1:0] w_c, h_c;
   logic [PixW:0]    col_sum;
   logic [PixW-1:0]  col_next;
   logic signed [SpanW-1:0] span_r, span_i;
   logic [PixW-1:0]  den;
   logic             div_start, div_done;
   logic signed [ProdW-1:0] quot;
   logic signed [VW-1:0] cr_val;

   assign w_c = mwe_pkg::clamp_size(width_cfg);
   assign h_c = mwe_pkg::clamp_size(height_cfg);
   assign wm1 = PixW'(w_c - 1'b1);
   assign hm1 = PixW'(h_c - 1'b1);
   assign span_r = SpanW'(real_max) - SpanW'(real_min);
   assign span_i = SpanW'(imag_max) - SpanW'(imag_min);
   assign col_sum  = {1'b0, first_ff} + {{(PixW+1-LaneW){1'b0}}, lane_ff};
   assign col_next = (col_sum > {1'b0, wm1}) ? wm1 : col_sum[PixW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mwe_pkg::FE_IDLE:    if (req_valid) state_in = mwe_pkg::FE_ROW_MUL;
         mwe_pkg::FE_ROW_MUL: state_in = mwe_pkg::FE_ROW_DIV;
         mwe_pkg::FE_ROW_DIV: if (div_done) state_in = mwe_pkg::FE_COL_MUL;
         mwe_pkg::FE_COL_MUL: state_in = mwe_pkg::FE_COL_DIV;
         mwe_pkg::FE_COL_DIV: if (div_done) state_in = mwe_pkg::FE_PUSH;
         mwe_pkg::FE_PUSH: begin
            if (push_ready) begin
               if (lane_ff == LaneW'(Lanes - 1)) state_in = mwe_pkg::FE_IDLE;
               else state_in = mwe_pkg::FE_COL_MUL;
            end
         end
         default: state_in = mwe_pkg::FE_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready = 1'b0;
      push      = 1'b0;
      div_start = 1'b0;
      first_in  = first_ff;
      row_in    = row_ff;
      lane_in   = lane_ff;
      col_in    = col_ff;
      ci_in     = ci_ff;
      prod_in   = prod_ff;
      den       = wm1;
      unique case (state_ff)
         mwe_pkg::FE_IDLE: begin
            req_ready = 1'b1;
            first_in  = (req_first_column > wm1) ? wm1 : req_first_column;
            row_in    = (req_row > hm1) ? hm1 : req_row;
            lane_in   = '0;
         end
         mwe_pkg::FE_ROW_MUL: begin
            prod_in   = ProdW'(span_i) * $signed({1'b0, row_ff});
            div_start = 1'b1;
         end
         mwe_pkg::FE_ROW_DIV: begin
            den = hm1;
            if (div_done) ci_in = VW'(imag_min) + VW'(quot);
         end
         mwe_pkg::FE_COL_MUL: begin
            col_in  = col_next;
            prod_in = ProdW'(span_r) * $signed({1'b0, col_next});
            div_start = 1'b1;
         end
         mwe_pkg::FE_COL_DIV: ;
         mwe_pkg::FE_PUSH: begin
            push = 1'b1;
            if (push_ready) lane_in = lane_ff + 1'b1;
         end
         default: ;
      endcase
   end

   // hold the quotient for the push cycle
   logic signed [VW-1:0] cr_ff, cr_in;
   assign cr_val = VW'(real_min) + VW'(quot);
   assign cr_in  = (state_ff == mwe_pkg::FE_COL_DIV && div_done) ? cr_val : cr_ff;

   mwe_divider #(.NumWidth(ProdW), .DenWidth(PixW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (prod_in),
      .denom ((state_ff == mwe_pkg::FE_ROW_MUL) ? hm1 : den),
      .done  (div_done),
      .quot  (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mwe_pkg::FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      first_ff <= first_in;
      row_ff   <= row_in;
      lane_ff  <= lane_in;
      col_ff   <= col_in;
      ci_ff    <= ci_in;
      prod_ff  <= prod_in;
      cr_ff    <= cr_in;
   end

   assign push_lane = lane_ff;
   assign push_col  = col_ff;
   assign push_cr   = cr_ff;
   assign push_ci   = ci_ff;
endmodule

### rtl/mwe_back.sv
// Back end: loads lane records, iterates all lanes in lockstep, then emits results.
// Depends on mwe_pkg; fed by the lane queue in the top level.
`timescale 1ns / 1ps
module mwe_back #(
   parameter int Lanes      = 32,
   parameter int CoordWidth = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  logic [mwe_pkg::LaneWidth-1:0] pop_lane,
   input  logic [mwe_pkg::PixWidth-1:0]  pop_col,
   input  logic signed [CoordWidth+3:0]  pop_cr,
   input  logic signed [CoordWidth+3:0]  pop_ci,
   input  logic [mwe_pkg::IterWidth-1:0] limit_cfg,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mwe_pkg::LaneWidth-1:0] rsp_lane,
   output logic [mwe_pkg::PixWidth-1:0]  rsp_pixel_column,
   output logic [mwe_pkg::IterWidth-1:0] rsp_escape_iteration,
   output logic                          rsp_last,
   output logic [mwe_pkg::IterWidth-1:0] rsp_steps_run,
   output logic signed [mwe_pkg::DivWidth-1:0] rsp_divergence_step,
   output logic [mwe_pkg::SlotWidth-1:0] rsp_active_slots
);
   localparam int VW    = CoordWidth + 4;
   localparam int FB    = mwe_pkg::FracBits;
   localparam int IW    = mwe_pkg::IterWidth;
   localparam int LaneW = mwe_pkg::LaneWidth;
   localparam int CntW  = $clog2(Lanes + 1);
   localparam int SumW  = mwe_pkg::SlotWidth + 1;
   localparam int MagW  = 2 * VW - FB + 1;
   localparam logic [63:0] EscBound = 64'h1_0000_0000;

   mwe_pkg::be_state_type state_ff, state_in;
   logic signed [VW-1:0] cr_ff [Lanes];
   logic signed [VW-1:0] ci_ff [Lanes];
   logic signed [VW-1:0] zr_ff [Lanes];
   logic signed [VW-1:0] zi_ff [Lanes];
   logic [IW-1:0] it_ff [Lanes];
   logic [mwe_pkg::PixWidth-1:0] col_ff [Lanes];
   logic [Lanes-1:0] act_ff, act_in;
   logic signed [VW-1:0] zr_in [Lanes];
   logic signed [VW-1:0] zi_in [Lanes];
   logic [IW-1:0] it_in [Lanes];
   logic [Lanes-1:0] esc;
   logic [IW-1:0] limit;
   logic [IW-1:0] step_ff, step_in;
   logic [SumW-1:0] sum_ff, sum_in;
   logic signed [mwe_pkg::DivWidth-1:0] div_ff, div_in;
   logic [LaneW-1:0] emit_ff, emit_in;
   logic [CntW-1:0] count;
   logic phase_ff, phase_in;
   logic run_done;
   logic out_v_ff, out_v_in;
   logic [LaneW-1:0] o_lane_ff, o_lane_in;
   logic [mwe_pkg::PixWidth-1:0] o_col_ff, o_col_in;
   logic [IW-1:0] o_it_ff, o_it_in;
   logic o_last_ff, o_last_in;
   logic [IW-1:0] o_steps_ff, o_steps_in;
   logic signed [mwe_pkg::DivWidth-1:0] o_div_ff, o_div_in;
   logic [mwe_pkg::SlotWidth-1:0] o_slot_ff, o_slot_in;
   logic out_free;
   logic load_last;

   assign limit    = (limit_cfg == '0) ? mwe_pkg::LimitDefault : limit_cfg;
   assign out_free = !out_v_ff || rsp_ready;
   assign load_last = pop_valid && pop_lane == LaneW'(Lanes - 1);
   assign run_done  = count == '0 || step_ff == limit;

   // count active lanes
   always_comb begin
      count = '0;
      for (int k = 0; k < Lanes; k++) count = count + CntW'(act_ff[k]);
   end

   // per lane: one step of z in the update phase, the escape test in the next
   for (genvar k = 0; k < Lanes; k++) begin : g_lane
      logic signed [2*VW-1:0] prr, pii, pri;
      logic signed [VW-1:0] sr, si, ti;
      logic [VW-1:0] ar, ai;
      logic [2*VW-1:0] sqr, sqi;
      logic [MagW-1:0] mag2;

      // advance z = z*z + c
      always_comb begin
         prr = zr_ff[k] * zr_ff[k];
         pii = zi_ff[k] * zi_ff[k];
         pri = zr_ff[k] * zi_ff[k];
         sr  = VW'(prr >>> FB);
         si  = VW'(pii >>> FB);
         ti  = VW'((pri <<< 1) >>> FB);
         zr_in[k] = sr - si + cr_ff[k];
         zi_in[k] = ti + ci_ff[k];
         it_in[k] = it_ff[k] + 1'b1;
      end

      // test the stored z for escape
      always_comb begin
         ar  = zr_ff[k][VW-1] ? VW'(-zr_ff[k]) : VW'(zr_ff[k]);
         ai  = zi_ff[k][VW-1] ? VW'(-zi_ff[k]) : VW'(zi_ff[k]);
         sqr = ar * ar;
         sqi = ai * ai;
         mag2 = MagW'(sqr >> FB) + MagW'(sqi >> FB);
         esc[k] = (64'(ar) >= EscBound) || (64'(ai) >= EscBound) ||
                  (mag2 > (MagW'(4) << FB));
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mwe_pkg::BE_IDLE: if (pop_valid && load_last) state_in = mwe_pkg::BE_RUN;
         mwe_pkg::BE_RUN:  if (!phase_ff && run_done) state_in = mwe_pkg::BE_EMIT;
         mwe_pkg::BE_EMIT: begin
            if (out_free && emit_ff == LaneW'(Lanes - 1)) state_in = mwe_pkg::BE_IDLE;
         end
         default: state_in = mwe_pkg::BE_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      pop_ready = 1'b0;
      act_in  = act_ff;
      step_in = step_ff;
      sum_in  = sum_ff;
      div_in  = div_ff;
      emit_in = emit_ff;
      phase_in = phase_ff;
      out_v_in   = out_v_ff && !rsp_ready;
      o_lane_in  = o_lane_ff;
      o_col_in   = o_col_ff;
      o_it_in    = o_it_ff;
      o_last_in  = o_last_ff;
      o_steps_in = o_steps_ff;
      o_div_in   = o_div_ff;
      o_slot_in  = o_slot_ff;
      unique case (state_ff)
         mwe_pkg::BE_IDLE: begin
            pop_ready = 1'b1;
            act_in  = '1;
            step_in = '0;
            sum_in  = '0;
            div_in  = '1;
            emit_in = '0;
            phase_in = 1'b0;
         end
         mwe_pkg::BE_RUN: begin
            if (!phase_ff) begin
               // update phase: account for the step and move z
               if (!run_done) begin
                  sum_in  = sum_ff + SumW'(count);
                  step_in = step_ff + 1'b1;
                  if (div_ff[mwe_pkg::DivWidth-1] && count != CntW'(Lanes))
                     div_in = {1'b0, step_ff};
                  phase_in = 1'b1;
               end
            end else begin
               // test phase: drop lanes that escaped or hit the limit
               for (int k = 0; k < Lanes; k++)
                  if (act_ff[k] && (esc[k] || it_ff[k] >= limit)) act_in[k] = 1'b0;
               phase_in = 1'b0;
            end
         end
         mwe_pkg::BE_EMIT: begin
            if (out_free) begin
               out_v_in  = 1'b1;
               o_lane_in = emit_ff;
               o_col_in  = col_ff[emit_ff];
               o_it_in   = act_ff[emit_ff] ? limit : it_ff[emit_ff];
               o_last_in = emit_ff == LaneW'(Lanes - 1);
               o_steps_in = o_last_in ? step_ff : '0;
               o_div_in   = o_last_in ? div_ff : '0;
               o_slot_in  = !o_last_in ? '0 :
                            (sum_ff[SumW-1] ? '1 : sum_ff[SumW-2:0]);
               emit_in = emit_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   logic run_step;
   assign run_step = state_ff == mwe_pkg::BE_RUN && !phase_ff && !run_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mwe_pkg::BE_IDLE;
         out_v_ff <= 1'b0;
         act_ff   <= '0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         act_ff   <= act_in;
         phase_ff <= phase_in;
      end
      step_ff <= step_in;
      sum_ff  <= sum_in;
      div_ff  <= div_in;
      emit_ff <= emit_in;
      o_lane_ff  <= o_lane_in;
      o_col_ff   <= o_col_in;
      o_it_ff    <= o_it_in;
      o_last_ff  <= o_last_in;
      o_steps_ff <= o_steps_in;
      o_div_ff   <= o_div_in;
      o_slot_ff  <= o_slot_in;
      for (int k = 0; k < Lanes; k++) begin
         if (state_ff == mwe_pkg::BE_IDLE && pop_valid && pop_lane == LaneW'(k)) begin
            cr_ff[k]  <= pop_cr;
            ci_ff[k]  <= pop_ci;
            col_ff[k] <= pop_col;
            zr_ff[k]  <= '0;
            zi_ff[k]  <= '0;
            it_ff[k]  <= '0;
         end else if (run_step && act_ff[k]) begin
            zr_ff[k] <= zr_in[k];
            zi_ff[k] <= zi_in[k];
            it_ff[k] <= it_in[k];
         end
      end
   end

   assign rsp_valid            = out_v_ff;
   assign rsp_lane             = o_lane_ff;
   assign rsp_pixel_column     = o_col_ff;
   assign rsp_escape_iteration = o_it_ff;
   assign rsp_last             = o_last_ff;
   assign rsp_steps_run        = o_steps_ff;
   assign rsp_divergence_step  = o_div_ff;
   assign rsp_active_slots     = o_slot_ff;
endmodule

### rtl/mwe_queue.sv
// Two-entry lane record queue between the front and back ends.
// Depends on nothing; width is a parameter.
`timescale 1ns / 1ps
module mwe_queue #(
   parameter int Width = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             push_ready,
   input  logic [Width-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop,
   output logic [Width-1:0] pop_data
);
   logic [Width-1:0] mem_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       do_push, do_pop;

   assign push_ready = cnt_ff != 2'd2;
   assign pop_valid  = cnt_ff != 2'd0;
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_data   = mem_ff[rd_ff];

   // advance pointers and count
   always_comb begin
      rd_in  = do_pop ? !rd_ff : rd_ff;
      wr_in  = do_push ? !wr_ff : wr_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (do_push) mem_ff[wr_ff] <= push_data;
   end
endmodule

### rtl/mandelbrot_warp_escape_core.sv
// Top level of the warp escape-time engine: registers, front end, queue, back end.
// Depends on mwe_pkg, mwe_front, mwe_queue and mwe_back.
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | first_column, row
//   rsp     | out       | rsp_valid / rsp_ready  | lane .. active_slots
//   csr     | in        | csr_valid / csr_ready  | csr_index, csr_data
// At the default widths the front end takes an item while idle, maps the row (setup
// plus a shift divider) and then each lane (setup, divider, push) for all 32 lanes.
// The back end then runs each lockstep step as an update and an escape test, plus a
// final check that sees the end, then emits the lane results one by one.
// Reset is synchronous and clears all control state. Result stalls hold the back end;
// a full queue holds the front.
`timescale 1ns / 1ps
module mandelbrot_warp_escape_core #(
   parameter int WarpWidth  = mwe_pkg::WarpWidthDefault,
   parameter int CoordWidth = mwe_pkg::CoordWidthDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [mwe_pkg::PixWidth-1:0] req_first_column,
   input  logic [mwe_pkg::PixWidth-1:0] req_row,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [mwe_pkg::LaneWidth-1:0] rsp_lane,
   output logic [mwe_pkg::PixWidth-1:0]  rsp_pixel_column,
   output logic [mwe_pkg::IterWidth-1:0] rsp_escape_iteration,
   output logic rsp_last,
   output logic [mwe_pkg::IterWidth-1:0] rsp_steps_run,
   output logic signed [mwe_pkg::DivWidth-1:0] rsp_divergence_step,
   output logic [mwe_pkg::SlotWidth-1:0] rsp_active_slots,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [mwe_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [CoordWidth-1:0] csr_data
);
   localparam int Lanes = (WarpWidth < mwe_pkg::ResultCap) ? WarpWidth : mwe_pkg::ResultCap;
   localparam int VW    = CoordWidth + 4;
   localparam int RecW  = mwe_pkg::LaneWidth + mwe_pkg::PixWidth + 2 * VW;

   logic [mwe_pkg::SizeWidth-1:0] width_ff, height_ff;
   logic [mwe_pkg::IterWidth-1:0] limit_ff;
   logic signed [CoordWidth-1:0] rmin_ff, rmax_ff, imin_ff, imax_ff;

   // write the configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd640;
         height_ff <= 13'd480;
         limit_ff  <= 16'd128;
         rmin_ff   <= CoordWidth'(-64'sd536870912);
         rmax_ff   <= CoordWidth'(64'sd268435456);
         imin_ff   <= CoordWidth'(-64'sd268435456);
         imax_ff   <= CoordWidth'(64'sd268435456);
      end else if (csr_valid) begin
         case (mwe_pkg::csr_idx_type'(csr_index))
            mwe_pkg::CSR_IMAGE_WIDTH:     width_ff  <= mwe_pkg::SizeWidth'(csr_data);
            mwe_pkg::CSR_IMAGE_HEIGHT:    height_ff <= mwe_pkg::SizeWidth'(csr_data);
            mwe_pkg::CSR_ITERATION_LIMIT: limit_ff  <= mwe_pkg::IterWidth'(csr_data);
            mwe_pkg::CSR_REAL_MIN:        rmin_ff   <= csr_data;
            mwe_pkg::CSR_REAL_MAX:        rmax_ff   <= csr_data;
            mwe_pkg::CSR_IMAG_MIN:        imin_ff   <= csr_data;
            mwe_pkg::CSR_IMAG_MAX:        imax_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   logic push, push_ready, pop_valid, pop_ready;
   logic [mwe_pkg::LaneWidth-1:0] f_lane;
   logic [mwe_pkg::PixWidth-1:0]  f_col;
   logic signed [VW-1:0] f_cr, f_ci;
   logic [RecW-1:0] pop_data;

   mwe_front #(.Lanes(Lanes), .CoordWidth(CoordWidth)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_first_column, .req_row,
      .width_cfg(width_ff), .height_cfg(height_ff),
      .real_min(rmin_ff), .real_max(rmax_ff), .imag_min(imin_ff), .imag_max(imax_ff),
      .push, .push_ready, .push_lane(f_lane), .push_col(f_col),
      .push_cr(f_cr), .push_ci(f_ci)
   );

   mwe_queue #(.Width(RecW)) u_queue (
      .clock, .reset, .push, .push_ready,
      .push_data({f_lane, f_col, f_cr, f_ci}),
      .pop_valid, .pop(pop_ready), .pop_data
   );

   mwe_back #(.Lanes(Lanes), .CoordWidth(CoordWidth)) u_back (
      .clock, .reset, .pop_valid, .pop_ready,
      .pop_lane(pop_data[RecW-1 -: mwe_pkg::LaneWidth]),
      .pop_col(pop_data[2*VW +: mwe_pkg::PixWidth]),
      .pop_cr(pop_data[VW +: VW]),
      .pop_ci(pop_data[0 +: VW]),
      .limit_cfg(limit_ff),
      .rsp_valid, .rsp_ready, .rsp_lane, .rsp_pixel_column, .rsp_escape_iteration,
      .rsp_last, .rsp_steps_run, .rsp_divergence_step, .rsp_active_slots
   );

   // a held result must stay valid and keep its lane
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_lane))
      else $error("result changed while stalled");

   // only the final lane carries totals
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_steps_run == '0 && rsp_active_slots == '0)
      else $error("totals on a non-final lane");

   // the last flag sits on the final lane only
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_lane == mwe_pkg::LaneWidth'(Lanes - 1))
      else $error("last flag on wrong lane");
endmodule

### tb/tb.sv
// Self-checking bench for mandelbrot_warp_escape_core: directed and random warps,
// predicted in place and checked per lane result. Depends on mwe_pkg and the core.
`timescale 1ns / 1ps
module tb;

   typedef struct {
      logic [mwe_pkg::LaneWidth-1:0]       lane;
      logic [mwe_pkg::PixWidth-1:0]        column;
      logic [mwe_pkg::IterWidth-1:0]       escape_iter;
      logic                                last;
      logic [mwe_pkg::IterWidth-1:0]       steps;
      logic signed [mwe_pkg::DivWidth-1:0] div_step;
      logic [mwe_pkg::SlotWidth-1:0]       slots;
   } lane_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [mwe_pkg::PixWidth-1:0] req_first_column = '0;
   logic [mwe_pkg::PixWidth-1:0] req_row = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [mwe_pkg::LaneWidth-1:0] rsp_lane;
   logic [mwe_pkg::PixWidth-1:0] rsp_pixel_column;
   logic [mwe_pkg::IterWidth-1:0] rsp_escape_iteration;
   logic rsp_last;
   logic [mwe_pkg::IterWidth-1:0] rsp_steps_run;
   logic signed [mwe_pkg::DivWidth-1:0] rsp_divergence_step;
   logic [mwe_pkg::SlotWidth-1:0] rsp_active_slots;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [mwe_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   // shadow copy of the register file
   logic [mwe_pkg::SizeWidth-1:0] width_reg = 13'd640;
   logic [mwe_pkg::SizeWidth-1:0] height_reg = 13'd480;
   logic [mwe_pkg::IterWidth-1:0] limit_reg = 16'd128;
   logic signed [31:0] re_lo = -32'sd536870912;
   logic signed [31:0] re_hi = 32'sd268435456;
   logic signed [31:0] im_lo = -32'sd268435456;
   logic signed [31:0] im_hi = 32'sd268435456;

   logic [2*mwe_pkg::PixWidth-1:0] warp_queue[$];
   lane_result_type lane_results[$];
   int send_idle = 34;
   int recv_stall = 67;
   int mismatches = 0;
   logic [2*mwe_pkg::PixWidth-1:0] next_warp;

   mandelbrot_warp_escape_core dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint map_axis(longint lo, longint hi, longint p, longint sz);
      return lo + ((hi - lo) * p) / (sz - 1);
   endfunction

   function automatic longint floor_frac(longint v);
      return v >>> mwe_pkg::FracBits;
   endfunction

   function automatic bit has_escaped(longint zr, longint zi);
      longint unsigned ar, ai;
      ar = zr < 0 ? -zr : zr;
      ai = zi < 0 ? -zi : zi;
      if (ar >= 64'd4294967296 || ai >= 64'd4294967296) return 1'b1;
      return ((ar * ar) >> mwe_pkg::FracBits) + ((ai * ai) >> mwe_pkg::FracBits)
             > (64'd4 << mwe_pkg::FracBits);
   endfunction

   // run one warp in lockstep and queue its lane results
   function automatic void predict_warp(logic [mwe_pkg::PixWidth-1:0] fc,
                                        logic [mwe_pkg::PixWidth-1:0] rw);
      longint w, h, first, row, ci, nr, ni;
      longint cr[32], zr[32], zi[32], cols[32];
      int unsigned it[32];
      bit act[32];
      int unsigned lim, cnt, steps, slots;
      int divg;
      lane_result_type r;
      w = (width_reg < 2) ? 2 : (width_reg > 4096) ? 4096 : width_reg;
      h = (height_reg < 2) ? 2 : (height_reg > 4096) ? 4096 : height_reg;
      lim = (limit_reg == 0) ? 128 : limit_reg;
      first = (fc > w - 1) ? w - 1 : fc;
      row = (rw > h - 1) ? h - 1 : rw;
      ci = map_axis(im_lo, im_hi, row, h);
      for (int k = 0; k < 32; k++) begin
         cols[k] = (first + k > w - 1) ? w - 1 : first + k;
         cr[k] = map_axis(re_lo, re_hi, cols[k], w);
         zr[k] = 0;
         zi[k] = 0;
         it[k] = 0;
         act[k] = 1'b1;
      end
      steps = 0;
      slots = 0;
      divg = -1;
      for (int unsigned s = 0; s < lim; s++) begin
         cnt = 0;
         for (int k = 0; k < 32; k++) cnt += act[k];
         if (cnt == 0) break;
         slots += cnt;
         steps = s + 1;
         if (divg < 0 && cnt < 32) divg = int'(s);
         for (int k = 0; k < 32; k++) begin
            if (act[k]) begin
               nr = floor_frac(zr[k] * zr[k]) - floor_frac(zi[k] * zi[k]) + cr[k];
               ni = floor_frac(2 * zr[k] * zi[k]) + ci;
               zr[k] = nr;
               zi[k] = ni;
               it[k]++;
               if (has_escaped(nr, ni) || it[k] >= lim) act[k] = 1'b0;
            end
         end
      end
      for (int k = 0; k < 32; k++) begin
         r.lane = mwe_pkg::LaneWidth'(k);
         r.column = mwe_pkg::PixWidth'(cols[k]);
         r.escape_iter = mwe_pkg::IterWidth'(act[k] ? lim : it[k]);
         r.last = (k == 31);
         r.steps = r.last ? mwe_pkg::IterWidth'(steps) : '0;
         r.div_step = r.last ? mwe_pkg::DivWidth'(divg) : '0;
         r.slots = !r.last ? '0 :
                   ((slots > 32'h1F_FFFF) ? '1 : mwe_pkg::SlotWidth'(slots));
         lane_results.insert(lane_results.size(), r);
      end
   endfunction

   // present warps from the queue, predict each one as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_warp(req_first_column, req_row);
         if (!req_valid || req_ready) begin
            if (warp_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
               next_warp = warp_queue.pop_front();
               req_valid <= 1'b1;
               req_first_column <= next_warp[2*mwe_pkg::PixWidth-1:mwe_pkg::PixWidth];
               req_row <= next_warp[mwe_pkg::PixWidth-1:0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // stall the result side at random and check every lane result taken
   always @(posedge clock) begin
      lane_result_type e;
      rsp_ready <= ($urandom_range(99) >= recv_stall);
      if (!reset && rsp_valid && rsp_ready) begin
         if (lane_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected lane result, lane %0d", rsp_lane);
         end else begin
            e = lane_results.pop_front();
            if (rsp_lane !== e.lane || rsp_pixel_column !== e.column ||
                rsp_escape_iteration !== e.escape_iter || rsp_last !== e.last ||
                rsp_steps_run !== e.steps || rsp_divergence_step !== e.div_step ||
                rsp_active_slots !== e.slots) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp lane %0d col %0d iter %0d last %0d",
                     e.lane, e.column, e.escape_iter, e.last,
                     " steps %0d div %0d slots %0d", e.steps, e.div_step, e.slots);
                  $display("          got lane %0d col %0d iter %0d last %0d",
                     rsp_lane, rsp_pixel_column, rsp_escape_iteration, rsp_last,
                     " steps %0d div %0d slots %0d", rsp_steps_run,
                     rsp_divergence_step, rsp_active_slots);
               end
            end
         end
      end
   end

   task automatic write_reg(mwe_pkg::csr_idx_type idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         mwe_pkg::CSR_IMAGE_WIDTH:     width_reg = val[mwe_pkg::SizeWidth-1:0];
         mwe_pkg::CSR_IMAGE_HEIGHT:    height_reg = val[mwe_pkg::SizeWidth-1:0];
         mwe_pkg::CSR_ITERATION_LIMIT: limit_reg = val[mwe_pkg::IterWidth-1:0];
         mwe_pkg::CSR_REAL_MIN:        re_lo = val;
         mwe_pkg::CSR_REAL_MAX:        re_hi = val;
         mwe_pkg::CSR_IMAG_MIN:        im_lo = val;
         mwe_pkg::CSR_IMAG_MAX:        im_hi = val;
         default: ;
      endcase
   endtask

   task automatic add_warp(int col, int rw);
      warp_queue.insert(warp_queue.size(),
                        {col[mwe_pkg::PixWidth-1:0], rw[mwe_pkg::PixWidth-1:0]});
   endtask

   // wait for every queued warp to be taken and every lane result to come back;
   // sample mid-cycle so a warp just taken from the queue is already on req_valid
   task automatic drain();
      while (warp_queue.size() > 0 || req_valid || lane_results.size() > 0)
         @(negedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic random_setup(bit wild);
      write_reg(mwe_pkg::CSR_IMAGE_WIDTH, $urandom_range(2, 300));
      write_reg(mwe_pkg::CSR_IMAGE_HEIGHT, $urandom_range(2, 300));
      write_reg(mwe_pkg::CSR_ITERATION_LIMIT, $urandom_range(1, 200));
      if (wild) begin
         write_reg(mwe_pkg::CSR_REAL_MIN, $urandom);
         write_reg(mwe_pkg::CSR_REAL_MAX, $urandom);
         write_reg(mwe_pkg::CSR_IMAG_MIN, $urandom);
         write_reg(mwe_pkg::CSR_IMAG_MAX, $urandom);
      end else begin
         write_reg(mwe_pkg::CSR_REAL_MIN, -$urandom_range(0, 32'h2800_0000));
         write_reg(mwe_pkg::CSR_REAL_MAX, $urandom_range(0, 32'h1800_0000));
         write_reg(mwe_pkg::CSR_IMAG_MIN, -$urandom_range(0, 32'h1800_0000));
         write_reg(mwe_pkg::CSR_IMAG_MAX, $urandom_range(0, 32'h1800_0000));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // default registers: corners, out-of-image, right edge clamp
      add_warp(0, 0);
      add_warp(4095, 4095);
      add_warp(620, 240);
      add_warp(608, 479);
      add_warp(300, 200);
      drain();

      // small image, zero limit, unknown register
      write_reg(mwe_pkg::CSR_IMAGE_WIDTH, 1);
      write_reg(mwe_pkg::CSR_IMAGE_HEIGHT, 0);
      write_reg(mwe_pkg::CSR_ITERATION_LIMIT, 0);
      write_reg(mwe_pkg::CSR_UNUSED, 32'hFFFF_FFFF);
      add_warp(0, 0);
      add_warp(1, 1);
      add_warp(2730, 1365);
      drain();

      // oversized image, limit of one, extreme plane edges
      write_reg(mwe_pkg::CSR_IMAGE_WIDTH, 8191);
      write_reg(mwe_pkg::CSR_IMAGE_HEIGHT, 4096);
      write_reg(mwe_pkg::CSR_ITERATION_LIMIT, 1);
      write_reg(mwe_pkg::CSR_REAL_MIN, 32'h8000_0000);
      write_reg(mwe_pkg::CSR_REAL_MAX, 32'h7FFF_FFFF);
      write_reg(mwe_pkg::CSR_IMAG_MIN, 32'h8000_0000);
      write_reg(mwe_pkg::CSR_IMAG_MAX, 32'h7FFF_FFFF);
      add_warp(0, 0);
      add_warp(4095, 4095);
      add_warp(2048, 2048);
      add_warp(4070, 100);
      drain();

      // largest limit on lanes that mostly stay bounded
      write_reg(mwe_pkg::CSR_IMAGE_WIDTH, 64);
      write_reg(mwe_pkg::CSR_IMAGE_HEIGHT, 2);
      write_reg(mwe_pkg::CSR_ITERATION_LIMIT, 65535);
      write_reg(mwe_pkg::CSR_REAL_MIN, -32'sd134217728);
      write_reg(mwe_pkg::CSR_REAL_MAX, 32'sd67108864);
      write_reg(mwe_pkg::CSR_IMAG_MIN, 0);
      write_reg(mwe_pkg::CSR_IMAG_MAX, 32'sd67108864);
      add_warp(0, 0);
      add_warp(40, 1);
      drain();

      // random warps under three idling patterns
      for (int m = 0; m < 3; m++) begin
         send_idle = (m == 0) ? 34 : (m == 1) ? 67 : 0;
         recv_stall = (m == 0) ? 67 : (m == 1) ? 34 : 0;
         for (int g = 0; g < 4; g++) begin
            random_setup(g == 3);
            for (int i = 0; i < 7; i++) begin
               if ($urandom_range(1))
                  add_warp($urandom_range(0, 4095), $urandom_range(0, 4095));
               else
                  add_warp($urandom_range(0, width_reg), $urandom_range(0, height_reg));
            end
            drain();
         end
      end

      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
